// ===== hw/rtl/pfrc_pkg.sv =====
// pfrc_pkg: types, codes and constants shared by the rule-chain classifier
// depends on nothing
package pfrc_pkg;

  localparam int RULES_PER_HOOK_DEF = 16;
  localparam int NUM_HOOKS_DEF      = 5;
  localparam int NUM_POLICY         = 5;
  localparam int CNT_W              = 9;   // holds a chain count up to 511
  localparam int PADDR_W            = 5;

  typedef enum logic [2:0] {
    REQ_EVAL  = 3'd0,
    REQ_ADD   = 3'd1,
    REQ_DEL   = 3'd2,
    REQ_FLUSH = 3'd3,
    REQ_READ  = 3'd4
  } req_t;

  localparam logic [1:0] ACT_ACCEPT = 2'd0;
  localparam logic [1:0] ACT_REJECT = 2'd2;
  localparam logic [1:0] ACT_LOG    = 2'd3;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } st_t;

  // request held steady for the whole walk
  typedef struct packed {
    logic [2:0]       req;
    logic [2:0]       hook;
    logic [7:0]       proto;
    logic [31:0]      sip;
    logic [31:0]      smask;
    logic [31:0]      dip;
    logic [31:0]      dmask;
    logic [31:0]      sport;
    logic [31:0]      dport;
    logic [7:0]       ifp;
    logic [1:0]       act;
    logic [15:0]      li;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  // token handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        done;
    logic [1:0]  verdict;
    logic [31:0] pk;
    logic [63:0] by;
  } tok_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] smask;
    logic [31:0] dst;
    logic [31:0] dmask;
    logic [63:0] ports;   // dst range 63:32, src range 31:0
    logic [17:0] pia;     // action 17:16, iface 15:8, proto 7:0
    logic [31:0] pk;
    logic [63:0] by;
  } rule_t;

endpackage

// ===== hw/rtl/pfrc_if.sv =====
// pfrc_req_if / pfrc_rsp_if: valid/ready channels for requests and results
// depends on nothing
interface pfrc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [2:0]  hook;
  logic [7:0]  proto;
  logic [31:0] src_ip;
  logic [31:0] src_netmask;
  logic [31:0] dst_ip;
  logic [31:0] dst_netmask;
  logic [31:0] src_port_range;
  logic [31:0] dst_port_range;
  logic [7:0]  iface_pair;
  logic [1:0]  rule_action;
  logic [15:0] length_or_index;
  modport source (output valid, req_type, hook, proto, src_ip, src_netmask, dst_ip,
                  dst_netmask, src_port_range, dst_port_range, iface_pair, rule_action,
                  length_or_index, input ready);
  modport sink (input valid, req_type, hook, proto, src_ip, src_netmask, dst_ip,
                dst_netmask, src_port_range, dst_port_range, iface_pair, rule_action,
                length_or_index, output ready);
endinterface

interface pfrc_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [1:0]  verdict;
  logic [3:0]  rule_slot;
  logic [31:0] packets_matched;
  logic [63:0] bytes_matched;
  modport source (output valid, status, verdict, rule_slot, packets_matched, bytes_matched,
                  input ready);
  modport sink (input valid, status, verdict, rule_slot, packets_matched, bytes_matched,
                output ready);
endinterface

// ===== hw/rtl/pfrc_cell.sv =====
// pfrc_cell: one rule slot of every chain; matches, counts, shifts and reports
// depends on pfrc_pkg
module pfrc_cell #(
  parameter int IDX            = 0,
  parameter int NUM_HOOKS      = 5,
  parameter int RULES_PER_HOOK = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  pfrc_pkg::cmd_t  cmd,
  input  pfrc_pkg::tok_t  tok_in,
  input  pfrc_pkg::rule_t nb_rule,
  output pfrc_pkg::rule_t my_rule,
  output pfrc_pkg::tok_t  tok_out
);
  import pfrc_pkg::*;

  localparam int HIDX = (NUM_HOOKS > 1) ? $clog2(NUM_HOOKS) : 1;
  localparam logic [CNT_W-1:0] MY_SLOT = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(RULES_PER_HOOK);

  rule_t ent [NUM_HOOKS];
  rule_t e, ent_next;
  tok_t  tok_next;
  logic  wr, in_chain, hit, idx_ok;
  logic  [HIDX-1:0] hidx;
  logic  [15:0] slo, shi, dlo, dhi, sp, dp;
  logic  [3:0]  rin, rout, pin, pout;

  assign hidx    = cmd.hook[HIDX-1:0];
  assign e       = ent[hidx];
  assign my_rule = e;

  always_comb begin
    slo = e.ports[15:0];
    shi = e.ports[31:16];
    dlo = e.ports[47:32];
    dhi = e.ports[63:48];
    sp  = cmd.sport[15:0];
    dp  = cmd.dport[15:0];
    rin = e.pia[11:8];
    rout = e.pia[15:12];
    pin = cmd.ifp[3:0];
    pout = cmd.ifp[7:4];
    hit = (e.pia[7:0] == 8'd0 || e.pia[7:0] == cmd.proto) &&
          (((cmd.sip ^ e.src) & e.smask) == 32'd0) &&
          (((cmd.dip ^ e.dst) & e.dmask) == 32'd0) &&
          ((slo == 16'd0 && shi == 16'd0) || (sp >= slo && sp <= shi)) &&
          ((dlo == 16'd0 && dhi == 16'd0) || (dp >= dlo && dp <= dhi)) &&
          (rin == 4'd0 || rin == pin) && (rout == 4'd0 || rout == pout);
  end

  assign in_chain = MY_SLOT < cmd.cnt;
  assign idx_ok   = cmd.li < 16'(cmd.cnt);

  always_comb begin
    tok_next = tok_in;
    ent_next = e;
    wr       = 1'b0;
    unique case (cmd.req)
      REQ_EVAL: begin
        if (in_chain && !tok_in.done && hit) begin
          ent_next.pk = e.pk + 32'd1;
          ent_next.by = e.by + {48'd0, cmd.li};
          wr = 1'b1;
          if (e.pia[17:16] != ACT_LOG) begin
            tok_next.done    = 1'b1;
            tok_next.verdict = e.pia[17:16];
          end
        end
      end
      REQ_ADD: begin
        if (cmd.cnt == MY_SLOT && cmd.cnt < MAX_CNT) begin
          ent_next.src   = cmd.sip;
          ent_next.smask = cmd.smask;
          ent_next.dst   = cmd.dip;
          ent_next.dmask = cmd.dmask;
          ent_next.ports = {cmd.dport, cmd.sport};
          ent_next.pia   = {cmd.act, cmd.ifp, cmd.proto};
          ent_next.pk    = 32'd0;
          ent_next.by    = 64'd0;
          wr = 1'b1;
        end
      end
      REQ_DEL: begin
        // right neighbor is untouched yet, the token moves left to right
        if (idx_ok && 16'(IDX) >= cmd.li && (MY_SLOT + CNT_W'(1)) < cmd.cnt) begin
          ent_next = nb_rule;
          wr = 1'b1;
        end
      end
      REQ_READ: begin
        if (idx_ok && cmd.li == 16'(IDX)) begin
          tok_next.pk = e.pk;
          tok_next.by = e.by;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid && wr) begin
      ent[hidx] <= ent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== hw/rtl/packet_filter_rule_chains.sv =====
// packet_filter_rule_chains: top level, request control, chain counts, policy registers
// depends on pfrc_pkg, pfrc_if, pfrc_cell
module packet_filter_rule_chains #(
  parameter int RULES_PER_HOOK = pfrc_pkg::RULES_PER_HOOK_DEF,
  parameter int NUM_HOOKS      = pfrc_pkg::NUM_HOOKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  pfrc_req_if.sink                      in_ch,
  pfrc_rsp_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfrc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  // Every request is handled one at a time. A request with a valid hook sends a token
  // down a row of RULES_PER_HOOK cells, one cell per cycle; each cell holds one rule
  // slot of every chain and matches, counts, shifts down or reports that slot as the
  // token passes. The result is registered once the token leaves the last cell; a request
  // with a bad hook or unknown type skips the row and is answered directly. A finished
  // result waits in the output register, so the next request is taken right after a walk
  // ends; a second finished result is held behind it and stops new requests until the
  // output drains. Policy registers sit at byte addresses 4*hook.
  import pfrc_pkg::*;

  localparam int HIDX = (NUM_HOOKS > 1) ? $clog2(NUM_HOOKS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(RULES_PER_HOOK);

  st_t  state, state_next;
  cmd_t cmd;
  logic launch;
  logic [CNT_W-1:0] cnt [NUM_HOOKS];
  logic [1:0] pol [NUM_POLICY];
  tok_t  tok [RULES_PER_HOOK+1];
  rule_t rl  [RULES_PER_HOOK+1];

  logic acc, good, wr_cnt;
  logic walk_end, fin, o_free;
  logic [CNT_W-1:0] cnt_new;
  logic [HIDX-1:0]  in_hidx, cmd_hidx;
  logic [2:0] cfg_idx;
  logic [1:0] pol_v;
  logic        ovalid, ostatus;
  logic [1:0]  overdict;
  logic [3:0]  oslot;
  logic [31:0] opk;
  logic [63:0] oby;
  logic        avalid, astatus;
  logic [1:0]  averdict;
  logic [3:0]  aslot;
  logic [31:0] apk;
  logic [63:0] aby;
  logic        r_status;
  logic [1:0]  r_verdict;
  logic [3:0]  r_slot;
  logic [31:0] r_pk;
  logic [63:0] r_by;
  logic        idx_ok;

  assign in_ch.ready = (state == ST_IDLE) && !avalid;
  assign acc  = in_ch.valid && in_ch.ready;
  assign good = (4'(in_ch.hook) < 4'(NUM_HOOKS)) && (in_ch.req_type <= REQ_READ);
  assign in_hidx  = in_ch.hook[HIDX-1:0];
  assign cmd_hidx = cmd.hook[HIDX-1:0];
  assign walk_end = (state == ST_WALK) && tok[RULES_PER_HOOK].valid;
  assign fin      = (acc && !good) || walk_end;
  assign o_free   = !ovalid || out_ch.ready;

  // apb
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign prdata  = (cfg_idx < 3'(NUM_POLICY)) ? {30'd0, pol[cfg_idx]} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_POLICY; k++) pol[k] <= 2'd0;
    end else if (psel && penable && pwrite && cfg_idx < 3'(NUM_POLICY)) begin
      pol[cfg_idx] <= pwdata[1:0];
    end
  end

  // cell row
  assign tok[0] = '{valid: launch, done: 1'b0, verdict: 2'd0, pk: 32'd0, by: 64'd0};
  assign rl[RULES_PER_HOOK] = '0;

  for (genvar g = 0; g < RULES_PER_HOOK; g++) begin : g_cell
    pfrc_cell #(
      .IDX(g), .NUM_HOOKS(NUM_HOOKS), .RULES_PER_HOOK(RULES_PER_HOOK)
    ) u_cell (
      .clk(clk), .rst(rst), .cmd(cmd), .tok_in(tok[g]), .nb_rule(rl[g+1]),
      .my_rule(rl[g]), .tok_out(tok[g+1])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (acc && good) state_next = ST_WALK;
      ST_WALK: if (tok[RULES_PER_HOOK].valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // result of a finished walk
  always_comb begin
    pol_v = (cmd.hook < 3'(NUM_POLICY)) ? pol[cmd.hook] : ACT_ACCEPT;
    if (pol_v == ACT_LOG) pol_v = ACT_REJECT;
    idx_ok    = cmd.li < 16'(cmd.cnt);
    r_status  = ST_OK;
    r_verdict = 2'd0;
    r_slot    = 4'd0;
    r_pk      = 32'd0;
    r_by      = 64'd0;
    wr_cnt    = 1'b0;
    cnt_new   = cmd.cnt;
    unique case (cmd.req)
      REQ_EVAL: begin
        r_verdict = tok[RULES_PER_HOOK].done ? tok[RULES_PER_HOOK].verdict : pol_v;
      end
      REQ_ADD: begin
        if (cmd.cnt < MAX_CNT) begin
          r_slot  = 4'(cmd.cnt);
          wr_cnt  = 1'b1;
          cnt_new = cmd.cnt + CNT_W'(1);
        end else begin
          r_status = ST_ERR;
        end
      end
      REQ_DEL: begin
        if (idx_ok) begin
          wr_cnt  = 1'b1;
          cnt_new = cmd.cnt - CNT_W'(1);
        end else begin
          r_status = ST_ERR;
        end
      end
      REQ_FLUSH: begin
        wr_cnt  = 1'b1;
        cnt_new = '0;
      end
      REQ_READ: begin
        if (idx_ok) begin
          r_pk = tok[RULES_PER_HOOK].pk;
          r_by = tok[RULES_PER_HOOK].by;
        end else begin
          r_status = ST_ERR;
        end
      end
      default: r_status = ST_ERR;
    endcase
    // a request refused at the input carries only the error status
    if (state != ST_WALK) begin
      r_status  = ST_ERR;
      r_verdict = 2'd0;
      r_slot    = 4'd0;
      r_pk      = 32'd0;
      r_by      = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
      ovalid <= 1'b0;
      avalid <= 1'b0;
      for (int k = 0; k < NUM_HOOKS; k++) cnt[k] <= '0;
    end else begin
      state  <= state_next;
      launch <= acc && good;
      if (walk_end && wr_cnt) cnt[cmd_hidx] <= cnt_new;
      // held result moves up first; a new one parks behind a stalled output
      if (avalid) begin
        if (o_free) begin
          ovalid <= 1'b1;
          avalid <= 1'b0;
        end
      end else if (fin) begin
        if (o_free) ovalid <= 1'b1;
        else avalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (acc) begin
      cmd <= '{req: in_ch.req_type, hook: in_ch.hook, proto: in_ch.proto,
               sip: in_ch.src_ip, smask: in_ch.src_netmask, dip: in_ch.dst_ip,
               dmask: in_ch.dst_netmask, sport: in_ch.src_port_range,
               dport: in_ch.dst_port_range, ifp: in_ch.iface_pair,
               act: in_ch.rule_action, li: in_ch.length_or_index,
               cnt: cnt[in_hidx]};
    end
    if (avalid) begin
      if (o_free) begin
        ostatus  <= astatus;
        overdict <= averdict;
        oslot    <= aslot;
        opk      <= apk;
        oby      <= aby;
      end
    end else if (fin) begin
      if (o_free) begin
        ostatus  <= r_status;
        overdict <= r_verdict;
        oslot    <= r_slot;
        opk      <= r_pk;
        oby      <= r_by;
      end else begin
        astatus  <= r_status;
        averdict <= r_verdict;
        aslot    <= r_slot;
        apk      <= r_pk;
        aby      <= r_by;
      end
    end
  end

  assign out_ch.valid           = ovalid;
  assign out_ch.status          = ostatus;
  assign out_ch.verdict         = overdict;
  assign out_ch.rule_slot       = oslot;
  assign out_ch.packets_matched = opk;
  assign out_ch.bytes_matched   = oby;

`ifndef SYNTH
  a_tail_in_walk: assert property (@(posedge clk) disable iff (rst)
    tok[RULES_PER_HOOK].valid |-> state == ST_WALK)
    else $error("token left the row outside a walk");
  a_tail_gives_result: assert property (@(posedge clk) disable iff (rst)
    tok[RULES_PER_HOOK].valid |=> ovalid)
    else $error("finished walk gave no result");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> cmd.cnt <= MAX_CNT)
    else $error("chain count above chain size");
  a_no_launch_busy: assert property (@(posedge clk) disable iff (rst)
    launch |-> $past(state) == ST_IDLE && !tok[RULES_PER_HOOK].valid)
    else $error("token launched while a walk was in flight");
  a_held_behind_out: assert property (@(posedge clk) disable iff (rst)
    avalid |-> ovalid)
    else $error("held result with an empty output");
`endif

endmodule

// ===== test/tb_packet_filter_rule_chains.sv =====
// tb_packet_filter_rule_chains: self-checking testbench for the rule-chain classifier,
// with directed and random requests checked against an in-bench chain predictor
// depends on pfrc_pkg, pfrc_if and packet_filter_rule_chains
module tb_packet_filter_rule_chains;
  import pfrc_pkg::*;

  localparam int RULES = RULES_PER_HOOK_DEF;
  localparam int HOOKS = NUM_HOOKS_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [2:0]  req_type;
    logic [2:0]  hook;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] src_netmask;
    logic [31:0] dst_ip;
    logic [31:0] dst_netmask;
    logic [31:0] src_port_range;
    logic [31:0] dst_port_range;
    logic [7:0]  iface_pair;
    logic [1:0]  rule_action;
    logic [15:0] length_or_index;
  } filter_req_t;

  typedef struct {
    logic        status;
    logic [1:0]  verdict;
    logic [3:0]  rule_slot;
    logic [31:0] packets_matched;
    logic [63:0] bytes_matched;
  } filter_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pfrc_req_if req_ch();
  pfrc_rsp_if rsp_ch();

  packet_filter_rule_chains dut (
    .clk(clk), .rst(rst), .in_ch(req_ch), .out_ch(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // chain predictor state
  rule_t       chain_rules [HOOKS][RULES];
  int unsigned chain_len [HOOKS];
  logic [1:0]  hook_policy [HOOKS];
  filter_rsp_t pending_rsp [$];

  int  fails = 0;
  int  n_sent = 0, n_checked = 0, n_matches = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;
  int  hold_left = 0, stall_left = 0, quiet_cycles = 0;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = '0; req_ch.hook = '0; req_ch.proto = '0;
    req_ch.src_ip = '0; req_ch.src_netmask = '0; req_ch.dst_ip = '0;
    req_ch.dst_netmask = '0;
    req_ch.src_port_range = '0; req_ch.dst_port_range = '0;
    req_ch.iface_pair = '0; req_ch.rule_action = '0; req_ch.length_or_index = '0;
    rsp_ch.ready = 1'b0;
    foreach (chain_len[h]) begin
      chain_len[h] = 0;
      hook_policy[h] = 2'd0;
    end
  end

  function automatic bit port_hit(logic [15:0] port, logic [31:0] range);
    if (range == 32'd0) return 1'b1;
    return port >= range[15:0] && port <= range[31:16];
  endfunction

  function automatic bit iface_hit(logic [3:0] pkt_id, logic [3:0] rule_id);
    return rule_id == 4'd0 || pkt_id == rule_id;
  endfunction

  // computes the result of one request and applies its effect on the chains
  function automatic filter_rsp_t classify(filter_req_t q);
    filter_rsp_t r;
    rule_t       ru;
    int unsigned h, n;
    bit          done;
    r = '{status: ST_ERR, verdict: 2'd0, rule_slot: 4'd0,
          packets_matched: 32'd0, bytes_matched: 64'd0};
    if (q.hook >= HOOKS) return r;
    h = q.hook;
    n = chain_len[h];
    case (q.req_type)
      REQ_EVAL: begin
        r.status = ST_OK;
        done = 1'b0;
        for (int i = 0; i < n && !done; i++) begin
          ru = chain_rules[h][i];
          if (ru.pia[7:0] != 8'd0 && ru.pia[7:0] != q.proto) continue;
          if (((q.src_ip ^ ru.src) & ru.smask) != 32'd0) continue;
          if (((q.dst_ip ^ ru.dst) & ru.dmask) != 32'd0) continue;
          if (!port_hit(q.src_port_range[15:0], ru.ports[31:0])) continue;
          if (!port_hit(q.dst_port_range[15:0], ru.ports[63:32])) continue;
          if (!iface_hit(q.iface_pair[3:0], ru.pia[11:8])) continue;
          if (!iface_hit(q.iface_pair[7:4], ru.pia[15:12])) continue;
          chain_rules[h][i].pk = ru.pk + 32'd1;
          chain_rules[h][i].by = ru.by + 64'(q.length_or_index);
          n_matches++;
          if (ru.pia[17:16] != ACT_LOG) begin
            r.verdict = ru.pia[17:16];
            done = 1'b1;
          end
        end
        if (!done) r.verdict = (hook_policy[h] > ACT_REJECT) ? ACT_REJECT : hook_policy[h];
      end
      REQ_ADD: begin
        if (n < RULES) begin
          chain_rules[h][n] = '{src: q.src_ip, smask: q.src_netmask, dst: q.dst_ip,
                                dmask: q.dst_netmask,
                                ports: {q.dst_port_range, q.src_port_range},
                                pia: {q.rule_action, q.iface_pair, q.proto},
                                pk: 32'd0, by: 64'd0};
          chain_len[h] = n + 1;
          r.rule_slot = 4'(n);
          r.status = ST_OK;
        end
      end
      REQ_DEL: begin
        if (q.length_or_index < n) begin
          for (int i = q.length_or_index; i + 1 < n; i++)
            chain_rules[h][i] = chain_rules[h][i+1];
          chain_len[h] = n - 1;
          r.status = ST_OK;
        end
      end
      REQ_FLUSH: begin
        chain_len[h] = 0;
        r.status = ST_OK;
      end
      REQ_READ: begin
        if (q.length_or_index < n) begin
          r.packets_matched = chain_rules[h][q.length_or_index].pk;
          r.bytes_matched = chain_rules[h][q.length_or_index].by;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // called right after a rising edge; returns right after the edge of the transfer
  task automatic send_req(filter_req_t q);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= q.req_type; req_ch.hook <= q.hook; req_ch.proto <= q.proto;
    req_ch.src_ip <= q.src_ip; req_ch.src_netmask <= q.src_netmask;
    req_ch.dst_ip <= q.dst_ip; req_ch.dst_netmask <= q.dst_netmask;
    req_ch.src_port_range <= q.src_port_range; req_ch.dst_port_range <= q.dst_port_range;
    req_ch.iface_pair <= q.iface_pair; req_ch.rule_action <= q.rule_action;
    req_ch.length_or_index <= q.length_or_index;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp.push_back(classify(q));
    n_sent++;
  endtask

  task automatic stop_sending();
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    stop_sending();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_policy(int idx, logic [1:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PADDR_W'(4 * idx); pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[1:0] !== val) begin
      $error("policy_hook_%0d: expected %0d, actual %0d", idx, val, prdata[1:0]);
      fails++;
    end
    psel <= 1'b0; penable <= 1'b0;
    hook_policy[idx] = val;
    @(posedge clk);
  endtask

  function automatic filter_req_t blank_req(logic [2:0] kind, logic [2:0] h);
    filter_req_t q;
    q = '{req_type: kind, hook: h, proto: 8'd0, src_ip: 32'd0, src_netmask: 32'd0,
          dst_ip: 32'd0, dst_netmask: 32'd0, src_port_range: 32'd0,
          dst_port_range: 32'd0, iface_pair: 8'd0, rule_action: 2'd0,
          length_or_index: 16'd0};
    return q;
  endfunction

  function automatic logic [31:0] pick_addr();
    return {8'd10, 8'd0, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 3))};
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'hFFFF_FF00;
      default: return 32'hFFFF_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_range();
    logic [15:0] lo;
    if ($urandom_range(0, 1) == 0) return 32'd0;
    lo = 16'($urandom_range(0, 40));
    return {lo + 16'($urandom_range(0, 40)), lo};
  endfunction

  function automatic logic [7:0] pick_proto(bit is_rule);
    case ($urandom_range(0, 2))
      0: return is_rule ? 8'd0 : 8'd1;
      1: return 8'd6;
      default: return 8'd17;
    endcase
  endfunction

  function automatic filter_req_t noise_req();
    filter_req_t q;
    q = '{req_type: 3'($urandom), hook: 3'($urandom), proto: 8'($urandom),
          src_ip: $urandom, src_netmask: $urandom, dst_ip: $urandom,
          dst_netmask: $urandom, src_port_range: $urandom, dst_port_range: $urandom,
          iface_pair: 8'($urandom), rule_action: 2'($urandom),
          length_or_index: 16'($urandom)};
    return q;
  endfunction

  // mostly well-formed requests drawn from small pools so rules and packets meet
  function automatic filter_req_t random_req();
    filter_req_t q;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    q = blank_req(REQ_EVAL, 3'($urandom_range(0, HOOKS - 1)));
    if (pick >= 92) return noise_req();
    if (pick >= 87) begin
      q = noise_req();
      if ($urandom_range(0, 1)) q.hook = 3'($urandom_range(HOOKS, 7));
      else q.req_type = 3'($urandom_range(5, 7));
      return q;
    end
    q.proto = pick_proto(pick >= 45 && pick < 65);
    q.length_or_index = 16'($urandom);
    q.iface_pair = {4'($urandom_range(0, 2)), 4'($urandom_range(0, 2))};
    q.src_ip = pick_addr();
    q.dst_ip = pick_addr();
    if (pick < 45) begin
      q.src_port_range = {16'($urandom), 16'($urandom_range(0, 90))};
      q.dst_port_range = {16'($urandom), 16'($urandom_range(0, 90))};
    end else if (pick < 65) begin
      q.req_type = REQ_ADD;
      q.src_netmask = pick_mask();
      q.dst_netmask = pick_mask();
      q.src_port_range = pick_range();
      q.dst_port_range = pick_range();
      q.rule_action = 2'($urandom);
    end else if (pick < 75) begin
      q.req_type = REQ_DEL;
      q.length_or_index = 16'($urandom_range(0, chain_len[q.hook]));
    end else if (pick < 85) begin
      q.req_type = REQ_READ;
      q.length_or_index = 16'($urandom_range(0, chain_len[q.hook]));
    end else begin
      q.req_type = REQ_FLUSH;
    end
    return q;
  endfunction

  task automatic send_random(int count);
    repeat (count) send_req(random_req());
  endtask

  task automatic test_empty_chains();
    for (int h = 0; h < HOOKS; h++) send_req(blank_req(REQ_EVAL, 3'(h)));
    wait_idle();
  endtask

  task automatic test_directed();
    filter_req_t q;
    q = blank_req(REQ_ADD, 3'd0);
    q.proto = 8'hFF; q.src_ip = '1; q.src_netmask = '1; q.dst_ip = '1; q.dst_netmask = '1;
    q.src_port_range = '1; q.dst_port_range = '1; q.iface_pair = 8'hFF;
    q.rule_action = 2'd1;
    send_req(q);
    q.req_type = REQ_EVAL; q.length_or_index = 16'hFFFF;
    send_req(q);
    q.iface_pair = 8'h0F;
    send_req(q);
    q = blank_req(REQ_READ, 3'd0);
    send_req(q);
    // a catch-all log rule counts, then the walk goes on to the accept rule
    q = blank_req(REQ_ADD, 3'd1); q.rule_action = ACT_LOG;
    send_req(q);
    q.rule_action = ACT_ACCEPT; q.proto = 8'd6;
    send_req(q);
    q = blank_req(REQ_EVAL, 3'd1); q.proto = 8'd6; q.length_or_index = 16'd100;
    send_req(q);
    q.proto = 8'd17;
    send_req(q);
    q = blank_req(REQ_ADD, 3'd2); q.rule_action = ACT_REJECT;
    q.src_port_range = {16'd20, 16'd10};
    send_req(q);
    q = blank_req(REQ_EVAL, 3'd2); q.src_port_range = 32'd15;
    send_req(q);
    q = blank_req(REQ_READ, 3'd1); q.length_or_index = 16'd1;
    send_req(q);
    // bad hooks, unknown requests, bad indexes
    send_req(blank_req(REQ_EVAL, 3'd5));
    send_req(blank_req(REQ_ADD, 3'd7));
    send_req(blank_req(3'd5, 3'd0));
    send_req(blank_req(3'd7, 3'd1));
    q = blank_req(REQ_DEL, 3'd1); q.length_or_index = 16'd2;
    send_req(q);
    q.length_or_index = 16'hFFFF; q.req_type = REQ_READ;
    send_req(q);
    q = blank_req(REQ_DEL, 3'd1);
    send_req(q);
    q = blank_req(REQ_READ, 3'd1);
    send_req(q);
    send_req(blank_req(REQ_FLUSH, 3'd0));
    send_req(blank_req(REQ_READ, 3'd0));
    // fill one chain past full
    q = blank_req(REQ_ADD, 3'd4); q.rule_action = ACT_LOG;
    repeat (RULES + 1) send_req(q);
    send_req(blank_req(REQ_EVAL, 3'd4));
    wait_idle();
  endtask

  task automatic test_policies();
    for (int h = 0; h < HOOKS; h++) set_policy(h, 2'(h % 4));
    for (int h = 0; h < HOOKS; h++) begin
      send_req(blank_req(REQ_FLUSH, 3'(h)));
      send_req(blank_req(REQ_EVAL, 3'(h)));
    end
    wait_idle();
    for (int h = 0; h < HOOKS; h++) set_policy(h, 2'd3);
    for (int h = 0; h < HOOKS; h++) send_req(blank_req(REQ_EVAL, 3'(h)));
    wait_idle();
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 4; phase++) begin
      for (int h = 0; h < HOOKS; h++) set_policy(h, 2'($urandom));
      send_random(250);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    send_random(40);
    wait_idle();
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    for (int h = 0; h < HOOKS; h++) set_policy(h, 2'd0);
    send_random(150);
    stop_sending();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_rsp();
    filter_rsp_t e;
    n_checked++;
    if (pending_rsp.size() == 0) begin
      $error("unexpected result transfer");
      fails++;
      return;
    end
    e = pending_rsp.pop_front();
    if (rsp_ch.status !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, rsp_ch.status); fails++;
    end
    if (rsp_ch.verdict !== e.verdict) begin
      $error("verdict: expected %0d, actual %0d", e.verdict, rsp_ch.verdict); fails++;
    end
    if (rsp_ch.rule_slot !== e.rule_slot) begin
      $error("rule_slot: expected %0d, actual %0d", e.rule_slot, rsp_ch.rule_slot); fails++;
    end
    if (rsp_ch.packets_matched !== e.packets_matched) begin
      $error("packets_matched: expected %0d, actual %0d", e.packets_matched,
             rsp_ch.packets_matched); fails++;
    end
    if (rsp_ch.bytes_matched !== e.bytes_matched) begin
      $error("bytes_matched: expected %0d, actual %0d", e.bytes_matched,
             rsp_ch.bytes_matched); fails++;
    end
  endtask

  // result side: checks each transfer and drives ready with bursts and one long hold
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) check_rsp();
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_chains();
    test_directed();
    test_policies();
    test_random_mix();
    test_backpressure();
    test_no_idle();
    $display("covered %0d requests (%0d results checked, %0d rule hits)",
             n_sent, n_checked, n_matches);
    $display("all request kinds, bad hooks and indexes, full chains, policy settings, stalls");
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
